// File: hdl/lcsr_pkg.sv
package lcsr_pkg;

	// Largest digit count the buffer and map can be built for.
	localparam int DigitMax = 8;
	localparam int DigitCount = 7;

	localparam int FrameBits = 13;
	localparam int CmdBits = 12;
	localparam int JobBits = 2 * FrameBits;
	localparam int CntW = $clog2(JobBits);

	localparam logic [2:0] WritePrefix = 3'b101;
	localparam logic [2:0] CmdPrefix = 3'b100;

	typedef enum logic [1:0] {
		OP_STORE   = 2'd0,
		OP_CMD     = 2'd1,
		OP_REFRESH = 2'd2,
		OP_MAP     = 2'd3
	} op_t;

	// One serial job: the wire bits MSB first, left aligned.
	typedef struct packed {
		logic                is_cmd;
		logic [JobBits-1:0]  bits;
	} job_t;

	// Controller RAM addresses that the map holds after reset.
	function automatic logic [5:0] reset_addr(input logic [2:0] digit, input logic half);
		logic [5:0] a;
		unique case (digit)
			3'd0: a = half ? 6'd13 : 6'd5;
			3'd1: a = half ? 6'd15 : 6'd14;
			3'd2: a = half ? 6'd17 : 6'd16;
			3'd3: a = half ? 6'd19 : 6'd18;
			3'd4: a = half ? 6'd27 : 6'd26;
			3'd5: a = half ? 6'd29 : 6'd28;
			3'd6: a = half ? 6'd0  : 6'd30;
			default: a = 6'd0;
		endcase
		return a;
	endfunction

endpackage

// File: hdl/lcsr_item_if.sv
interface lcsr_item_if;
	logic       valid;
	logic       ready;
	logic [1:0] opcode;
	logic [2:0] digit_index;
	logic [7:0] segment_byte;
	logic [8:0] command_code;
	logic       map_half;
	logic [5:0] map_address;

	modport source (
		output valid, opcode, digit_index, segment_byte, command_code, map_half, map_address,
		input  ready
	);
	modport sink (
		input  valid, opcode, digit_index, segment_byte, command_code, map_half, map_address,
		output ready
	);
endinterface

// File: hdl/lcsr_bit_if.sv
interface lcsr_bit_if;
	logic valid;
	logic ready;
	logic wire_bit;
	logic frame_start;
	logic frame_end;
	logic run_last;

	modport source (
		output valid, wire_bit, frame_start, frame_end, run_last,
		input  ready
	);
	modport sink (
		input  valid, wire_bit, frame_start, frame_end, run_last,
		output ready
	);
endinterface

// File: hdl/lcsr_front.sv
module lcsr_front #(
	parameter int DIGIT_COUNT = lcsr_pkg::DigitCount
) (
	input  logic              clk,
	input  logic              arst_n,
	lcsr_item_if.sink         item,
	input  logic              queue_full,
	output logic              push,
	output lcsr_pkg::job_t    job
);

	localparam int IdxW = (DIGIT_COUNT > 1) ? $clog2(DIGIT_COUNT) : 1;
	localparam logic [3:0] DigitLimit = 4'(DIGIT_COUNT);
	localparam logic [IdxW-1:0] PtrLast = IdxW'(DIGIT_COUNT - 1);

	logic [7:0]      buffer_q [DIGIT_COUNT];
	logic [5:0]      map_q [DIGIT_COUNT][2];
	logic [IdxW-1:0] ptr_q;

	logic            accept;
	logic            in_range;
	logic [IdxW-1:0] widx;
	lcsr_pkg::op_t   op;
	logic [7:0]      cur_byte;
	logic [5:0]      addr_lo;
	logic [5:0]      addr_hi;

	assign op = lcsr_pkg::op_t'(item.opcode);
	assign item.ready = !queue_full;
	assign accept = item.valid && item.ready;
	assign in_range = {1'b0, item.digit_index} < DigitLimit;
	assign widx = item.digit_index[IdxW-1:0];

	assign cur_byte = buffer_q[ptr_q];
	assign addr_lo = map_q[ptr_q][0];
	assign addr_hi = map_q[ptr_q][1];

	assign push = accept && (op == lcsr_pkg::OP_CMD || op == lcsr_pkg::OP_REFRESH);

	// Jobs are resolved against the state as it stands when the item is taken.
	always_comb begin
		job.is_cmd = (op == lcsr_pkg::OP_CMD);
		if (job.is_cmd) begin
			job.bits = {lcsr_pkg::CmdPrefix, item.command_code,
				(lcsr_pkg::JobBits - lcsr_pkg::CmdBits)'(0)};
		end else begin
			job.bits = {lcsr_pkg::WritePrefix, addr_lo,
				cur_byte[0], cur_byte[1], cur_byte[2], cur_byte[3],
				lcsr_pkg::WritePrefix, addr_hi,
				cur_byte[4], cur_byte[5], cur_byte[6], cur_byte[7]};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < DIGIT_COUNT; i++) begin
				buffer_q[i] <= 8'd0;
				map_q[i][0] <= lcsr_pkg::reset_addr(3'(i), 1'b0);
				map_q[i][1] <= lcsr_pkg::reset_addr(3'(i), 1'b1);
			end
			ptr_q <= '0;
		end else if (accept) begin
			case (op)
				lcsr_pkg::OP_STORE: begin
					if (in_range) buffer_q[widx] <= item.segment_byte;
				end
				lcsr_pkg::OP_MAP: begin
					if (in_range) map_q[widx][item.map_half] <= item.map_address;
				end
				lcsr_pkg::OP_REFRESH: begin
					ptr_q <= (ptr_q == PtrLast) ? '0 : ptr_q + 1'b1;
				end
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/lcsr_queue.sv
module lcsr_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  lcsr_pkg::job_t push_job,
	input  logic           pop,
	output lcsr_pkg::job_t head,
	output logic           full,
	output logic           empty
);

	lcsr_pkg::job_t slot_q [2];
	logic           wr_q;
	logic           rd_q;
	logic [1:0]     count_q;

	assign head = slot_q[rd_q];
	assign empty = (count_q == 2'd0);
	assign full = (count_q == 2'd2);

	always_ff @(posedge clk) begin
		if (push) slot_q[wr_q] <= push_job;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			count_q <= 2'd0;
		end else begin
			if (push) wr_q <= ~wr_q;
			if (pop) rd_q <= ~rd_q;
			case ({push, pop})
				2'b10: count_q <= count_q + 2'd1;
				2'b01: count_q <= count_q - 2'd1;
				default: ;
			endcase
		end
	end

endmodule

// File: hdl/lcsr_back.sv
module lcsr_back (
	input  logic                clk,
	input  logic                arst_n,
	input  lcsr_pkg::job_t      head,
	input  logic                empty,
	output logic                pop,
	lcsr_bit_if.source          bits
);

	localparam int CntW = lcsr_pkg::CntW;

	lcsr_pkg::job_t  job_q;
	logic            active_q;
	logic [CntW-1:0] cnt_q;
	logic            valid_q;
	logic            wire_bit_q;
	logic            start_q;
	logic            end_q;
	logic            last_q;

	logic emit;
	logic last_bit;
	logic mid_end;
	logic mid_start;

	assign emit = active_q && (!valid_q || bits.ready);
	assign last_bit = job_q.is_cmd ? (cnt_q == CntW'(lcsr_pkg::CmdBits - 1))
		: (cnt_q == CntW'(lcsr_pkg::JobBits - 1));
	assign mid_end = !job_q.is_cmd && (cnt_q == CntW'(lcsr_pkg::FrameBits - 1));
	assign mid_start = !job_q.is_cmd && (cnt_q == CntW'(lcsr_pkg::FrameBits));
	assign pop = !empty && (!active_q || (emit && last_bit));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			cnt_q <= '0;
			valid_q <= 1'b0;
		end else begin
			if (pop) begin
				active_q <= 1'b1;
				cnt_q <= '0;
			end else if (emit && last_bit) begin
				active_q <= 1'b0;
			end else if (emit) begin
				cnt_q <= cnt_q + 1'b1;
			end
			if (emit) valid_q <= 1'b1;
			else if (bits.ready) valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) job_q <= head;
		else if (emit) job_q.bits <= job_q.bits << 1;
		if (emit) begin
			wire_bit_q <= job_q.bits[lcsr_pkg::JobBits-1];
			start_q <= (cnt_q == '0) || mid_start;
			end_q <= last_bit || mid_end;
			last_q <= last_bit;
		end
	end

	assign bits.valid = valid_q;
	assign bits.wire_bit = wire_bit_q;
	assign bits.frame_start = start_q;
	assign bits.frame_end = end_q;
	assign bits.run_last = last_q;

endmodule

// File: hdl/lcd_controller_serial_refresher_unit.sv
// Channel  | Role   | Payload
// item     | sink   | opcode, digit_index, segment_byte, command_code, map_half, map_address
// bits     | source | wire_bit, frame_start, frame_end, run_last
//
// A store or map-load item produces no job.
// A command produces 12 bit transfers and a refresh 26, one per cycle while the
// output is ready; the output bit register and the serializer counter set that pace.
// Jobs follow one another back to back while the two-entry queue holds work.
// Reset is asynchronous and active low; buffer, map and pointer return at once.
// A stalled output holds the serializer; items keep entering until the queue fills.

module lcd_controller_serial_refresher_unit #(
	parameter int DIGIT_COUNT = lcsr_pkg::DigitCount
) (
	input  logic        clk,
	input  logic        arst_n,
	lcsr_item_if.sink   item,
	lcsr_bit_if.source  bits
);

	// Jobs travel from the front end to the serializer through a short queue.
	lcsr_pkg::job_t push_job;
	lcsr_pkg::job_t head;
	logic           push;
	logic           pop;
	logic           full;
	logic           empty;

	// The front end decodes every item transfer, applies stores and map loads
	// to its registers, and turns commands and refreshes into complete bit jobs.
	lcsr_front #(
		.DIGIT_COUNT(DIGIT_COUNT)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.item(item),
		.queue_full(full),
		.push(push),
		.job(push_job)
	);

	// The queue lets the front end keep taking items while a job is shifted out.
	lcsr_queue u_queue (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_job(push_job),
		.pop(pop),
		.head(head),
		.full(full),
		.empty(empty)
	);

	// The serializer shifts each job out one bit transfer at a time and marks
	// frame boundaries and the final bit of each job.
	lcsr_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.head(head),
		.empty(empty),
		.pop(pop),
		.bits(bits)
	);

endmodule
